/* design/spq_pkg.sv */
// shared types and constants for the sorted priority queue
// no dependencies; used by spq_ctrl, spq_datapath and sorted_priority_queue

package spq_pkg;

    localparam int DEPTH      = 16;
    localparam int PRIO_BITS  = 8;
    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = $clog2(DEPTH + 1);
    localparam int STAT_BITS  = 2;

    // request codes carried by req_type
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // result status codes
    localparam logic [STAT_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_BITS-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_BITS-1:0] STAT_EMPTY = 2'd2;

    // operation the datapath carries out on a load
    typedef enum logic [1:0] {
        OP_INSERT      = 2'd0,
        OP_REMOVE      = 2'd1,
        OP_FLAG_FULL   = 2'd2,
        OP_FLAG_EMPTY  = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stat_t;

endpackage

/* design/sorted_priority_queue.sv */
// top level of the sorted priority queue
// depends on spq_pkg, spq_ctrl and spq_datapath
//
// usage
//   input channel s_*: one word per request; s_req_type selects enqueue
//   (s_data_in stored with priority s_prio_in) or dequeue of the head
//   result channel m_*: exactly one word per request, carrying status,
//   dequeued data and priority (zero unless a dequeue succeeded) and
//   the fill level after the request
// timing and throughput
//   an accepted request's result is shown on the next cycle; one request
//   per cycle is sustained while m_ready stays high, by the parallel
//   compare and shift of the sixteen slot registers
// ordering
//   smaller priority number leaves first; among equal priorities the most
//   recently enqueued entry leaves first
//   an enqueue to a full queue is dropped and flagged; a dequeue from an
//   empty queue is flagged
// reset
//   aresetn (synchronous, active low) empties the queue and drops any
//   pending result word; slot contents are not cleared
// stalls
//   a result word waits in the output register while m_ready is low; a new
//   request is taken in the same cycle that the waiting word is taken

module sorted_priority_queue (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic signed [spq_pkg::DATA_BITS-1:0] s_data_in,
    input  logic [spq_pkg::PRIO_BITS-1:0]        s_prio_in,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [spq_pkg::STAT_BITS-1:0]        m_status,
    output logic signed [spq_pkg::DATA_BITS-1:0] m_data_out,
    output logic [spq_pkg::PRIO_BITS-1:0]        m_prio_out,
    output logic [spq_pkg::COUNT_BITS-1:0]       m_fill_level
);

    // command from controller, full and empty flags back from datapath
    spq_pkg::cmd_t  cmd;
    spq_pkg::stat_t stat;

    // controller: handshakes and choice of operation
    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .req_type (s_req_type),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: sorted slots, count and result word register
    spq_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .data_in    (s_data_in),
        .prio_in    (s_prio_in),
        .status     (m_status),
        .data_out   (m_data_out),
        .prio_out   (m_prio_out),
        .fill_level (m_fill_level)
    );

endmodule

/* design/spq_ctrl.sv */
// handshake controller for the sorted priority queue
// depends on spq_pkg; drives commands into spq_datapath

module spq_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             req_type,
    output logic             m_valid,
    input  logic             m_ready,
    input  spq_pkg::stat_t   stat,
    output spq_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) || m_ready;
    assign m_valid = (state_reg == ST_HOLD);
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd.load = accept;
        if (req_type == spq_pkg::REQ_DEQ) begin
            cmd.op = stat.empty ? spq_pkg::OP_FLAG_EMPTY : spq_pkg::OP_REMOVE;
        end else begin
            cmd.op = stat.full ? spq_pkg::OP_FLAG_FULL : spq_pkg::OP_INSERT;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (accept)       state_next = ST_HOLD;
                else if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/spq_datapath.sv */
// sorted slot array, entry count and result register
// depends on spq_pkg; commanded by spq_ctrl

module spq_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  spq_pkg::cmd_t                          cmd,
    output spq_pkg::stat_t                         stat,
    input  logic signed [spq_pkg::DATA_BITS-1:0]   data_in,
    input  logic [spq_pkg::PRIO_BITS-1:0]          prio_in,
    output logic [spq_pkg::STAT_BITS-1:0]          status,
    output logic signed [spq_pkg::DATA_BITS-1:0]   data_out,
    output logic [spq_pkg::PRIO_BITS-1:0]          prio_out,
    output logic [spq_pkg::COUNT_BITS-1:0]         fill_level
);

    logic [spq_pkg::DATA_BITS-1:0]  data_reg [spq_pkg::DEPTH];
    logic [spq_pkg::DATA_BITS-1:0]  data_next [spq_pkg::DEPTH];
    logic [spq_pkg::PRIO_BITS-1:0]  prio_reg [spq_pkg::DEPTH];
    logic [spq_pkg::PRIO_BITS-1:0]  prio_next [spq_pkg::DEPTH];
    logic [spq_pkg::COUNT_BITS-1:0] count_reg;
    logic [spq_pkg::COUNT_BITS-1:0] count_next;
    logic [spq_pkg::DEPTH-1:0]      below;

    logic [spq_pkg::STAT_BITS-1:0]        status_reg;
    logic signed [spq_pkg::DATA_BITS-1:0] dout_reg;
    logic [spq_pkg::PRIO_BITS-1:0]        pout_reg;

    assign stat.full  = (count_reg == spq_pkg::COUNT_BITS'(spq_pkg::DEPTH));
    assign stat.empty = (count_reg == '0);

    // held slots that stay ahead of a new entry (a prefix, list is sorted)
    always_comb begin
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            below[i] = (spq_pkg::COUNT_BITS'(i) < count_reg) && (prio_reg[i] < prio_in);
        end
    end

    always_comb begin
        count_next = count_reg;
        for (int i = 0; i < spq_pkg::DEPTH; i++) begin
            data_next[i] = data_reg[i];
            prio_next[i] = prio_reg[i];
        end
        case (cmd.op)
            spq_pkg::OP_INSERT: begin
                for (int i = 0; i < spq_pkg::DEPTH; i++) begin
                    if (below[i]) begin
                        data_next[i] = data_reg[i];
                        prio_next[i] = prio_reg[i];
                    end else if (i == 0 || below[(i == 0) ? 0 : i - 1]) begin
                        data_next[i] = data_in;
                        prio_next[i] = prio_in;
                    end else begin
                        data_next[i] = data_reg[(i == 0) ? 0 : i - 1];
                        prio_next[i] = prio_reg[(i == 0) ? 0 : i - 1];
                    end
                end
                count_next = count_reg + 1'b1;
            end
            spq_pkg::OP_REMOVE: begin
                for (int i = 0; i < spq_pkg::DEPTH - 1; i++) begin
                    data_next[i] = data_reg[i + 1];
                    prio_next[i] = prio_reg[i + 1];
                end
                count_next = count_reg - 1'b1;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.load) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < spq_pkg::DEPTH; i++) begin
                data_reg[i] <= data_next[i];
                prio_reg[i] <= prio_next[i];
            end
            case (cmd.op)
                spq_pkg::OP_REMOVE: begin
                    status_reg <= spq_pkg::STAT_OK;
                    dout_reg   <= data_reg[0];
                    pout_reg   <= prio_reg[0];
                end
                spq_pkg::OP_FLAG_FULL: begin
                    status_reg <= spq_pkg::STAT_FULL;
                    dout_reg   <= '0;
                    pout_reg   <= '0;
                end
                spq_pkg::OP_FLAG_EMPTY: begin
                    status_reg <= spq_pkg::STAT_EMPTY;
                    dout_reg   <= '0;
                    pout_reg   <= '0;
                end
                default: begin
                    status_reg <= spq_pkg::STAT_OK;
                    dout_reg   <= '0;
                    pout_reg   <= '0;
                end
            endcase
        end
    end

    assign status     = status_reg;
    assign data_out   = dout_reg;
    assign prio_out   = pout_reg;
    assign fill_level = count_reg;

endmodule
